### design/stbg_pkg.sv
`timescale 1ns / 1ps
package stbg_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_TONE    = 2'd1,
    FUNC_SILENCE = 2'd2
  } func_t;

  localparam logic CFG_PHASE_STEP = 1'b0;
  localparam logic CFG_AMPLITUDE  = 1'b1;

  localparam logic [31:0] PHASE_STEP_RESET = 32'd348966093;
  localparam logic [14:0] AMPLITUDE_RESET  = 15'd7000;
  localparam logic [14:0] FULL_SCALE       = 15'd32767;

  typedef struct packed {
    logic valid;
    logic tone;
    logic last;
  } frame_req_t;

  // Q30 Taylor coefficients of sin(pi/2 * u)
  localparam logic [63:0] SIN_COEF [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026998, 64'd172272, 64'd3864
  };

  // round(32767 * sin(pi/2 * q / quarter)), elaboration only
  function automatic logic [15:0] quarter_sine(input int unsigned q, input int unsigned abits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    u  = 64'(q) << (32 - abits);
    u2 = (u * u) >> 30;
    r  = SIN_COEF[5];
    for (int i = 4; i >= 0; i--) begin
      r = SIN_COEF[i] - ((u2 * r) >> 30);
    end
    s = (u * r) >> 30;
    v = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (v > 64'(FULL_SCALE)) begin
      v = 64'(FULL_SCALE);
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned abits);
    int unsigned quarter;
    int unsigned quad;
    int unsigned q;
    logic [15:0] m;
    quarter = 32'd1 << (abits - 2);
    quad    = k >> (abits - 2);
    q       = k & (quarter - 1);
    m       = quad[0] ? quarter_sine(quarter - q, abits) : quarter_sine(q, abits);
    return quad[1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

### design/stbg_sine_rom.sv
`timescale 1ns / 1ps
module stbg_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ADDR_BITS-1:0] addr,
  output logic signed [15:0]   data
);
  import stbg_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic signed [15:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic signed [15:0] ENTRY = sine_entry(k, ADDR_BITS);
    assign rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

### design/stbg_ctrl.sv
`timescale 1ns / 1ps
module stbg_ctrl #(
  parameter int SAMPLE_RATE     = 16000,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [11:0]                burst_ms,
  input  logic                       cfg_write_en,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       adv,
  output logic [TABLE_ADDR_BITS-1:0] rom_addr,
  output stbg_pkg::frame_req_t       req,
  output logic [14:0]                tone_amplitude
);
  import stbg_pkg::*;

  // frames = floor(ms * rate / 1000) via exact reciprocal for 12-bit ms
  localparam int          RATE_SHIFT  = 24;
  localparam logic [63:0] RATE_MULT   = ((64'(SAMPLE_RATE) << RATE_SHIFT) + 64'd999) / 64'd1000;
  localparam logic [31:0] RATE_MULT_W = RATE_MULT[31:0];

  logic [31:0] phase_step;
  logic [31:0] phase_acc;
  logic [15:0] frames_left;
  logic        tone_on;

  logic        accept;
  logic        is_start;
  logic [43:0] burst_prod;
  logic [19:0] burst_frames;
  logic [15:0] frames_init;

  assign in_ready     = adv;
  assign accept       = in_valid && in_ready;
  assign is_start     = (func == FUNC_TONE) || (func == FUNC_SILENCE);
  assign burst_prod   = 44'(burst_ms) * 44'(RATE_MULT_W);
  assign burst_frames = burst_prod[RATE_SHIFT +: 20];
  assign frames_init  = (|burst_frames[19:16]) ? 16'hFFFF : burst_frames[15:0];

  assign req.valid = in_valid && (func == FUNC_TICK) && (frames_left != 16'd0);
  assign req.tone  = tone_on;
  assign req.last  = (frames_left == 16'd1);
  assign rom_addr  = phase_acc[31 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= PHASE_STEP_RESET;
      tone_amplitude <= AMPLITUDE_RESET;
      phase_acc      <= '0;
      frames_left    <= '0;
      tone_on        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_PHASE_STEP: phase_step     <= cfg_data;
          CFG_AMPLITUDE:  tone_amplitude <= cfg_data[14:0];
          default:        phase_step     <= phase_step;
        endcase
      end
      if (accept) begin
        if (is_start) begin
          phase_acc   <= '0;
          frames_left <= frames_init;
          tone_on     <= (func == FUNC_TONE);
        end else if (req.valid) begin
          phase_acc   <= phase_acc + phase_step;
          frames_left <= frames_left - 16'd1;
        end
      end
    end
  end

  a_frame_dec: assert property (@(posedge clk) disable iff (rst)
    accept && req.valid |=> frames_left == $past(frames_left) - 16'd1)
    else $error("frame count did not step");

  a_phase_adv: assert property (@(posedge clk) disable iff (rst)
    accept && req.valid |=> phase_acc == $past(phase_acc) + $past(phase_step))
    else $error("phase did not advance");

  a_start_clr: assert property (@(posedge clk) disable iff (rst)
    accept && is_start |=> phase_acc == 32'd0 && !req.last == (frames_left != 16'd1))
    else $error("start item did not reset phase");

endmodule

### design/stbg_scale.sv
`timescale 1ns / 1ps
module stbg_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  stbg_pkg::frame_req_t req,
  input  logic signed [15:0]   rom_data,
  input  logic [14:0]          tone_amplitude,
  output logic                 adv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   sample,
  output logic                 last_frame
);
  import stbg_pkg::*;

  // stage 1: table read in flight
  logic        v1;
  logic        tone1;
  logic        last1;
  // stage 2: product
  logic        v2;
  logic        neg2;
  logic        last2;
  logic [29:0] prod2;
  // stage 3: quotient estimate
  logic        v3;
  logic        neg3;
  logic        last3;
  logic [29:0] prod3;
  logic [15:0] quo3;

  logic        en2;
  logic        en3;
  logic        en_out;

  logic signed [15:0] rom_neg;
  logic [14:0]        mag;
  logic [30:0]        est_sum;
  logic [30:0]        rem;
  logic [15:0]        quo;

  assign en_out = !out_valid || out_ready;
  assign en3    = !v3 || en_out;
  assign en2    = !v2 || en3;
  assign adv    = !v1 || en2;

  assign rom_neg = -rom_data;
  assign mag     = !tone1 ? 15'd0 : (rom_data[15] ? rom_neg[14:0] : rom_data[14:0]);

  // x / 32767: estimate low by at most one, then one correction step
  assign est_sum = 31'(prod2) + 31'(prod2[29:15]);
  assign rem     = 31'(prod3) + 31'(quo3) - (31'(quo3) << 15);
  assign quo     = (rem >= 31'(FULL_SCALE)) ? quo3 + 16'd1 : quo3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        v1 <= req.valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_out) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tone1 <= req.tone;
      last1 <= req.last;
    end
    if (en2) begin
      neg2  <= tone1 && rom_data[15];
      last2 <= last1;
      prod2 <= 30'(mag) * 30'(tone_amplitude);
    end
    if (en3) begin
      neg3  <= neg2;
      last3 <= last2;
      prod3 <= prod2;
      quo3  <= est_sum[30:15];
    end
    if (en_out) begin
      sample     <= neg3 ? -$signed(quo) : $signed(quo);
      last_frame <= last3;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> rem < 31'(2 * 32767))
    else $error("quotient estimate off by more than one");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != 16'sh8000)
    else $error("sample out of range");

endmodule

### design/sine_tone_burst_generator.sv
`timescale 1ns / 1ps
// Tone burst generator: bursts of sine tone or silence as a stereo sample stream.
// Input channel (in_valid/in_ready): func selects tick, start tone or start silence;
// burst_ms sets the burst length of a start item (ms * SAMPLE_RATE / 1000 frames,
// capped at 65535). A start item clears the phase and emits nothing.
// Each tick during a burst emits one frame on the output channel (out_valid/out_ready):
// the same sample on left_sample and right_sample, last_frame on the burst's final frame.
// Ticks while idle and func code 3 are consumed with no result.
// Config port: cfg_write_en/cfg_index/cfg_data; index 0 phase_step, 1 tone_amplitude.
// Write it only while no item is in flight.
// Pipeline: a tick's frame passes the sine table read, amplitude multiply, quotient
// estimate and output register stages. Throughput: one item per cycle while out_ready
// holds, set by the single-port sine table and the four-stage scaling pipeline.
// Reset empties the pipeline, ends any burst, and restores phase_step (1300 Hz at
// 16 kHz) and amplitude 7000. The sine table is constant, so no fill is needed.
// When the receiver stalls, empty stages still fill; in_ready drops once all four
// stages hold a frame.
module sine_tone_burst_generator #(
  parameter int SAMPLE_RATE     = 16000,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [11:0]        burst_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               last_frame,
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import stbg_pkg::*;

  frame_req_t                 req;
  logic                       adv;
  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic signed [15:0]         rom_data;
  logic [14:0]                tone_amplitude;
  logic signed [15:0]         sample;

  stbg_ctrl #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .burst_ms       (burst_ms),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adv            (adv),
    .rom_addr       (rom_addr),
    .req            (req),
    .tone_amplitude (tone_amplitude)
  );

  stbg_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .data (rom_data)
  );

  stbg_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rom_data       (rom_data),
    .tone_amplitude (tone_amplitude),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .last_frame     (last_frame)
  );

  assign left_sample  = sample;
  assign right_sample = sample;

endmodule
